/* rtl/pfrc_pkg.sv */
// shared types, constants and register codes of the pcm format, rate and channel converter
`timescale 1ns / 1ps
`default_nettype none
package pfrc_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int MAX_REPEATS  = 8;

  localparam int RATE_W     = 21;
  localparam int RATE_MIN   = 8192;
  localparam int RATE_MAX   = 1048576;
  localparam int PHASE_ONE  = 65536;
  localparam int PH_W       = 24;
  localparam int FULL_SCALE = 32767;

  localparam int WORD_W = 32;
  localparam int SMP_W  = 16;
  localparam int MAN_W  = 24;
  localparam int PROD_W = MAN_W + 15;

  localparam int FMT_W   = 3;
  localparam int INCH_W  = 4;
  localparam int OUTCH_W = 2;
  localparam int IDX_W   = 2;

  localparam int NCH_W  = $clog2(MAX_CHANNELS + 1);
  localparam int CNT_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SUM_W  = SMP_W + $clog2(MAX_CHANNELS);
  localparam int REP_W  = $clog2(MAX_REPEATS + 1);

  // sample formats
  localparam logic [FMT_W-1:0] FMT_PCM16 = 3'd0;
  localparam logic [FMT_W-1:0] FMT_PCM24 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_PCM32 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_F32   = 3'd3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_FORMAT   = 2'd0;
  localparam logic [IDX_W-1:0] REG_IN_CH    = 2'd1;
  localparam logic [IDX_W-1:0] REG_OUT_CH   = 2'd2;
  localparam logic [IDX_W-1:0] REG_RATE     = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_LOOP,
    ST_EMIT0,
    ST_EMIT1
  } pfrc_state_t;

endpackage
`default_nettype wire

/* rtl/pfrc_conv.sv */
// sample word to signed 16-bit converter with a registered float scaling multiply
`timescale 1ns / 1ps
`default_nettype none
module pfrc_conv
  import pfrc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    load,
  input  wire logic [WORD_W-1:0]       word,
  input  wire logic [FMT_W-1:0]        fmt,
  output logic signed [SMP_W-1:0]      sample
);

  logic [WORD_W-1:0] word_r;
  logic [PROD_W-1:0] prod_r;
  logic [MAN_W-1:0]  man_in;
  logic [7:0]        ex;
  logic [7:0]        sh;
  logic [PROD_W-1:0] shifted;
  logic [14:0]       mag;
  logic signed [SMP_W-1:0] float_s;
  logic              is_nan;

  assign man_in = (word[30:23] == 8'd0) ? {1'b0, word[22:0]} : {1'b1, word[22:0]};

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= word;
      prod_r <= PROD_W'(man_in) * PROD_W'(FULL_SCALE);
    end
  end

  always_comb begin
    ex      = word_r[30:23];
    is_nan  = (ex == 8'hff) && (word_r[22:0] != 23'd0);
    // value is m * 2^(e - 150), so the scaled product shifts right by 150 - e
    sh      = 8'd150 - ((ex == 8'd0) ? 8'd1 : ex);
    shifted = (sh >= 8'(PROD_W)) ? '0 : (prod_r >> sh);
    if (ex >= 8'd127) mag = 15'(FULL_SCALE);
    else              mag = shifted[14:0];
    if (is_nan)          float_s = '0;
    else if (word_r[31]) float_s = -$signed({1'b0, mag});
    else                 float_s = $signed({1'b0, mag});
  end

  always_comb begin
    unique case (fmt)
      FMT_PCM16: sample = $signed(word_r[15:0]);
      FMT_PCM24: sample = $signed(word_r[23:8]);
      FMT_PCM32: sample = $signed(word_r[31:16]);
      FMT_F32:   sample = float_s;
      default:   sample = '0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/pfrc_div.sv */
// bit-serial restoring divider for the mono average, truncating toward zero
`timescale 1ns / 1ps
`default_nettype none
module pfrc_div
  import pfrc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [SUM_W-1:0] dividend,
  input  wire logic [NCH_W-1:0]        divisor,
  output logic                         done,
  output logic signed [SMP_W-1:0]      quotient
);

  localparam int DCNT_W = $clog2(SUM_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [NCH_W-1:0]  rem_r, rem_nxt;
  logic [NCH_W-1:0]  dvs_r, dvs_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic              neg_r, neg_nxt;
  logic [NCH_W:0]    trial;
  logic [NCH_W:0]    diff;
  logic              fits;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    neg_nxt  = neg_r;
    trial    = {rem_r, quo_r[SUM_W-1]};
    diff     = trial - {1'b0, dvs_r};
    fits     = trial >= {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(SUM_W);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      neg_nxt  = dividend[SUM_W-1];
      quo_nxt  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
    end else if (busy_r) begin
      // one quotient bit a cycle, msb first
      rem_nxt = fits ? diff[NCH_W-1:0] : trial[NCH_W-1:0];
      quo_nxt = {quo_r[SUM_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(SMP_W'(quo_r)) : $signed(SMP_W'(quo_r));

endmodule
`default_nettype wire

/* rtl/pcm_format_rate_channel_converter_unit.sv */
// Interleaved channel words go in one at a time; each is converted to signed 16 bits
// (pcm16/24/32 by taking the top 16 bits, float32 clamped and scaled by 32767), and
// on the last channel of a frame a mono average or stereo pair is emitted zero or more
// times by a Q8.16 signed drop/repeat phase accumulator. A word that does not end a
// frame is accepted with the float multiply, then accumulated. A frame-ending word also
// runs the bit-serial average divider, then one loop pass per output frame copy, each
// followed by its results, one per cycle as the output side takes them, and a last loop
// pass to close the phase. in_tready is high only while the sequencer is idle. A silent
// word is taken without leaving idle, yields nothing, and restarts frame assembly and
// the phase.
`timescale 1ns / 1ps
`default_nettype none
module pcm_format_rate_channel_converter_unit
  import pfrc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [WORD_W-1:0]   in_tdata,   // sample_word
  input  wire logic                in_tuser,   // silent
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [SMP_W-1:0]         out_tdata,  // out_sample
  output logic                     out_tuser,  // out_channel
  output logic                     out_tlast,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [IDX_W-1:0]    cfg_index,
  input  wire logic [RATE_W-1:0]   cfg_data
);

  pfrc_state_t state_r, state_nxt;

  logic [FMT_W-1:0]   fmt_r;
  logic [INCH_W-1:0]  in_ch_r;
  logic [OUTCH_W-1:0] out_ch_r;
  logic [RATE_W-1:0]  rate_r;

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [SMP_W-1:0] first_r, first_nxt;
  logic signed [SMP_W-1:0] second_r, second_nxt;
  logic signed [PH_W-1:0]  phase_r, phase_nxt;
  logic [REP_W-1:0]        reps_r, reps_nxt;
  logic                    last_iter_r, last_iter_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [SMP_W-1:0]  out_data_r, out_data_nxt;
  logic              out_ch_sel_r, out_ch_sel_nxt;
  logic              out_last_r, out_last_nxt;

  logic                    in_acc;
  logic                    conv_load;
  logic signed [SMP_W-1:0] conv_sample;
  logic                    div_start;
  logic                    div_done;
  logic signed [SMP_W-1:0] mono;
  logic [NCH_W-1:0]        n_c;
  logic [RATE_W-1:0]       step_c;
  logic signed [PH_W-1:0]  phase_add;
  logic                    phase_le0;
  logic                    add_le0;
  logic                    last_c;
  logic                    stereo;
  logic                    frame_end;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign conv_load  = in_acc && !in_tuser;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ch_sel_r;
  assign out_tlast  = out_last_r;

  pfrc_conv u_conv (
    .clk    (clk),
    .load   (conv_load),
    .word   (in_tdata),
    .fmt    (fmt_r),
    .sample (conv_sample)
  );

  // the divider starts on the accumulate cycle, so it takes the sum with this word in it
  pfrc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (n_c),
    .done     (div_done),
    .quotient (mono)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_PCM16;
      in_ch_r  <= 4'd2;
      out_ch_r <= 2'd1;
      rate_r   <= RATE_W'(PHASE_ONE);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FORMAT: fmt_r    <= cfg_data[FMT_W-1:0];
        REG_IN_CH:  in_ch_r  <= cfg_data[INCH_W-1:0];
        REG_OUT_CH: out_ch_r <= cfg_data[OUTCH_W-1:0];
        REG_RATE:   rate_r   <= cfg_data;
      endcase
    end
  end

  always_comb begin
    if (in_ch_r == '0)                                       n_c = NCH_W'(1);
    else if ({28'd0, in_ch_r} > 32'(MAX_CHANNELS))           n_c = NCH_W'(MAX_CHANNELS);
    else                                                     n_c = NCH_W'(in_ch_r);
    if (rate_r < RATE_W'(RATE_MIN))      step_c = RATE_W'(RATE_MIN);
    else if (rate_r > RATE_W'(RATE_MAX)) step_c = RATE_W'(RATE_MAX);
    else                                 step_c = rate_r;
  end

  assign stereo    = out_ch_r[1];
  assign frame_end = ((NCH_W+1)'(cnt_r) + 1'b1) >= (NCH_W+1)'(n_c);
  assign phase_add = phase_r + $signed(PH_W'(step_c));
  assign phase_le0 = phase_r[PH_W-1] || (phase_r == '0);
  assign add_le0   = phase_add[PH_W-1] || (phase_add == '0);
  // the final copy is the last pass of the loop or the one that hits the repeat cap
  assign last_c    = !add_le0 || (REP_W'(reps_r + 1'b1) == REP_W'(MAX_REPEATS));

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    sum_nxt        = sum_r;
    first_nxt      = first_r;
    second_nxt     = second_r;
    phase_nxt      = phase_r;
    reps_nxt       = reps_r;
    last_iter_nxt  = last_iter_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_ch_sel_nxt = out_ch_sel_r;
    out_last_nxt   = out_last_r;
    div_start      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser) begin
            phase_nxt = '0;
            cnt_nxt   = '0;
            sum_nxt   = '0;
          end else begin
            state_nxt = ST_ACC;
          end
        end
      end
      ST_ACC: begin
        if (cnt_r == '0) begin
          first_nxt  = conv_sample;
          second_nxt = conv_sample;
          sum_nxt    = SUM_W'(conv_sample);
        end else begin
          if (cnt_r == CNT_W'(1)) second_nxt = conv_sample;
          sum_nxt = sum_r + SUM_W'(conv_sample);
        end
        if (frame_end) begin
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        // sum_r holds the whole frame here
        if (div_done) state_nxt = ST_LOOP;
      end
      ST_LOOP: begin
        if (phase_le0) begin
          phase_nxt = phase_add;
          if (reps_r < REP_W'(MAX_REPEATS)) begin
            reps_nxt       = reps_r + 1'b1;
            last_iter_nxt  = last_c;
            out_valid_nxt  = 1'b1;
            out_data_nxt   = stereo ? first_r : mono;
            out_ch_sel_nxt = 1'b0;
            out_last_nxt   = stereo ? 1'b0 : last_c;
            state_nxt      = ST_EMIT0;
          end
        end else begin
          phase_nxt = phase_r - PH_W'(PHASE_ONE);
          reps_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT0: begin
        if (out_tready) begin
          if (stereo) begin
            out_data_nxt   = second_r;
            out_ch_sel_nxt = 1'b1;
            out_last_nxt   = last_iter_r;
            state_nxt      = ST_EMIT1;
          end else begin
            out_valid_nxt = 1'b0;
            state_nxt     = ST_LOOP;
          end
        end
      end
      ST_EMIT1: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_LOOP;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (state_r == ST_ACC && frame_end) div_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      first_r     <= '0;
      second_r    <= '0;
      phase_r     <= '0;
      reps_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      first_r     <= first_nxt;
      second_r    <= second_nxt;
      phase_r     <= phase_nxt;
      reps_r      <= reps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_iter_r  <= last_iter_nxt;
    out_data_r   <= out_data_nxt;
    out_ch_sel_r <= out_ch_sel_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule
`default_nettype wire
